>>> sv/value_noise_domain_warp_assert.svh
// Assertion macros used by the checker file.
`ifndef VALUE_NOISE_DOMAIN_WARP_ASSERT_SVH
`define VALUE_NOISE_DOMAIN_WARP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VNDW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VNDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/vndw_pkg.sv
// Shared constants, codes and arithmetic helpers for the value noise warp block.
package vndw_pkg;

    // Grid sizes must be powers of two: wrap is a bit truncation.
    localparam int GRID_X  = 128;
    localparam int GRID_Y  = 128;
    localparam int GX_BITS = $clog2(GRID_X);
    localparam int GY_BITS = $clog2(GRID_Y);
    localparam int ADDR_W  = GX_BITS + GY_BITS;
    localparam int CELLS   = GRID_X * GRID_Y;

    localparam int OUT_LIM = 38400;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_INV_X = 2'd1;
    localparam logic [1:0] CFG_INV_Y = 2'd2;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_FBM   = 2'd1;
    localparam logic [1:0] MODE_WARP  = 2'd2;

    // Warp offsets in Q16.16
    localparam logic signed [31:0] OFF_X0 = 32'sd661914;
    localparam logic signed [31:0] OFF_Y0 = 32'sd517734;
    localparam logic signed [31:0] OFF_X2 = 32'sd714342;
    localparam logic signed [31:0] OFF_Y2 = 32'sd596378;
    localparam logic signed [31:0] OFF_X3 = 32'sd1382810;
    localparam logic signed [31:0] OFF_Y3 = 32'sd216269;

    typedef struct packed {
        logic signed [31:0] idx;
        logic signed [16:0] frac;
    } split_t;

    // Round half away from zero to an integer cell, plus signed fraction.
    function automatic split_t split_pos(input logic signed [47:0] p);
        logic signed [47:0] bias;
        logic signed [47:0] i;
        logic signed [47:0] f;
        split_t r;
        bias = p[47] ? 48'sd32767 : 48'sd32768;
        i = (p + bias) >>> 16;
        f = p - (i <<< 16);
        r.idx = i[31:0];
        r.frac = f[16:0];
        return r;
    endfunction

    // x + 128*r + off, saturated to signed 32 bits.
    function automatic logic signed [31:0] warp_sum(input logic signed [31:0] x,
                                                    input logic signed [16:0] r,
                                                    input logic signed [31:0] off);
        logic signed [34:0] s;
        s = 35'(x) + (35'(r) <<< 7) + 35'(off);
        if (s > 35'sd2147483647)
            return 32'sh7fffffff;
        else if (s < -35'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

    // Round Q.46 fbm sum to Q.11 and saturate.
    function automatic logic signed [16:0] round_out(input logic signed [55:0] acc);
        logic signed [55:0] s;
        s = (acc + (56'sd1 <<< 34)) >>> 35;
        if (s > 56'(OUT_LIM))
            return 17'(OUT_LIM);
        else if (s < -56'(OUT_LIM))
            return -17'(OUT_LIM);
        else
            return s[16:0];
    endfunction

endpackage

>>> sv/value_noise_domain_warp.sv
// Value noise / fBm / domain warp evaluator over a loadable wrapping table.
// Load transaction: writes one table entry, no result. Evaluate: each fBm pass does the
// coordinate multiplies, then per octave the index, table reads and lerp/acc steps, then
// rounding; the result then moves to the output register, and input reopens after that.
// One shared 34x34 multiplier and the single table read port set the rate.
// Async active-low reset: idle, no result, mode=warp, inverse scales 1.0.
module value_noise_domain_warp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic signed [31:0]                  x_coord,
    input  logic signed [31:0]                  y_coord,
    input  logic [13:0]                         table_index,
    input  logic signed [15:0]                  table_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [16:0]                  noise_value
);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MX   = 4'd1;   // x * inv_scale_x
    localparam logic [3:0] S_MY   = 4'd2;   // y * inv_scale_y
    localparam logic [3:0] S_MYW  = 4'd3;   // capture y product
    localparam logic [3:0] S_IDX  = 4'd4;   // cell indices and weights
    localparam logic [3:0] S_RD   = 4'd5;   // four table reads
    localparam logic [3:0] S_LA   = 4'd6;   // wx * (t01 - t00)
    localparam logic [3:0] S_LB   = 4'd7;   // wx * (t11 - t10)
    localparam logic [3:0] S_LV   = 4'd8;   // capture row b
    localparam logic [3:0] S_LW   = 4'd9;   // wy * (b - a)
    localparam logic [3:0] S_ACC  = 4'd10;  // accumulate octave
    localparam logic [3:0] S_FBM  = 4'd11;  // round, set up next warp pass
    localparam logic [3:0] S_DONE = 4'd12;  // hand result to output register

    localparam int GXB = vndw_pkg::GX_BITS;
    localparam int GYB = vndw_pkg::GY_BITS;

    logic [3:0]               state_reg;
    logic [3:0]               state_next;

    // configuration
    logic [1:0]               mode_reg;
    logic [31:0]              inv_x_reg;
    logic [31:0]              inv_y_reg;

    // evaluation state
    logic signed [31:0]       x_reg, y_reg;       // original point
    logic signed [31:0]       cx_reg, cy_reg;     // point for current pass
    logic signed [16:0]       x2_reg, y2_reg, x3_reg;
    logic [2:0]               pass_reg;
    logic [1:0]               oct_reg;
    logic [2:0]               rd_cnt_reg;
    logic signed [63:0]       prx_reg, pry_reg;
    logic signed [63:0]       mul_reg;
    logic [GXB-1:0]           ix1_reg, ix2_reg;
    logic [GYB-1:0]           iy1_reg, iy2_reg;
    logic [16:0]              wx_reg, wy_reg;
    logic signed [15:0]       t_reg [4];
    logic signed [33:0]       a_reg, b_reg;
    logic signed [55:0]       acc_reg;
    logic signed [16:0]       res_reg;
    logic                     out_valid_reg;
    logic signed [16:0]       noise_value_reg;

    // table memory
    logic signed [15:0]       mem [vndw_pkg::CELLS];
    logic signed [15:0]       mem_q;
    logic [vndw_pkg::ADDR_W-1:0] rd_addr;

    logic                     in_acc;
    logic                     load_we;
    logic                     out_free;

    // shared multiplier
    logic signed [33:0]       mul_a, mul_b;
    logic signed [67:0]       mul_p;

    logic signed [16:0]       d01, d23;
    logic signed [47:0]       px, py;
    vndw_pkg::split_t         sx, sy;
    logic signed [49:0]       vsum;
    logic signed [16:0]       fbm_r;
    logic                     single_pass;
    logic [1:0]               last_oct;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign load_we     = in_acc && (operation == vndw_pkg::OP_LOAD)
                         && ({18'd0, table_index} < 32'(vndw_pkg::CELLS));
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_value_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    assign single_pass = (mode_reg == vndw_pkg::MODE_PLAIN) || (mode_reg == vndw_pkg::MODE_FBM);
    assign last_oct    = (mode_reg == vndw_pkg::MODE_PLAIN) ? 2'd0 : 2'd3;

    assign d01 = 17'(t_reg[1]) - 17'(t_reg[0]);
    assign d23 = 17'(t_reg[3]) - 17'(t_reg[2]);

    // Operand select for the one multiplier
    always_comb
    begin
        case (state_reg)
            S_MX:
            begin
                mul_a = 34'(cx_reg);
                mul_b = $signed({2'b00, inv_x_reg});
            end
            S_MY:
            begin
                mul_a = 34'(cy_reg);
                mul_b = $signed({2'b00, inv_y_reg});
            end
            S_LA:
            begin
                mul_a = 34'(d01);
                mul_b = $signed({17'd0, wx_reg});
            end
            S_LB:
            begin
                mul_a = 34'(d23);
                mul_b = $signed({17'd0, wx_reg});
            end
            S_LW:
            begin
                mul_a = b_reg - a_reg;
                mul_b = $signed({17'd0, wy_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Octave k scales position by 2^-k: floor shift of the stored product
    assign px = 48'(prx_reg >>> (16 + int'(oct_reg)));
    assign py = 48'(pry_reg >>> (16 + int'(oct_reg)));
    assign sx = vndw_pkg::split_pos(px);
    assign sy = vndw_pkg::split_pos(py);

    assign vsum  = (50'(a_reg) <<< 16) + 50'(mul_reg);
    assign fbm_r = vndw_pkg::round_out(acc_reg);

    // Read order: (y1,x1) (y1,x2) (y2,x1) (y2,x2)
    always_comb
    begin
        case (rd_cnt_reg[1:0])
            2'd0:    rd_addr = {iy1_reg, ix1_reg};
            2'd1:    rd_addr = {iy1_reg, ix2_reg};
            2'd2:    rd_addr = {iy2_reg, ix1_reg};
            default: rd_addr = {iy2_reg, ix2_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
            mem[table_index[vndw_pkg::ADDR_W-1:0]] <= table_value;
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_acc && operation == vndw_pkg::OP_EVAL)
                    state_next = S_MX;
            S_MX:   state_next = S_MY;
            S_MY:   state_next = S_MYW;
            S_MYW:  state_next = S_IDX;
            S_IDX:  state_next = S_RD;
            S_RD:
                if (rd_cnt_reg == 3'd4)
                    state_next = S_LA;
            S_LA:   state_next = S_LB;
            S_LB:   state_next = S_LV;
            S_LV:   state_next = S_LW;
            S_LW:   state_next = S_ACC;
            S_ACC:  state_next = (oct_reg == last_oct) ? S_FBM : S_IDX;
            S_FBM:  state_next = (single_pass || pass_reg == 3'd4) ? S_DONE : S_MX;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= vndw_pkg::MODE_WARP;
            inv_x_reg     <= 32'd65536;
            inv_y_reg     <= 32'd65536;
            out_valid_reg <= 1'b0;
            pass_reg      <= 3'd0;
            oct_reg       <= 2'd0;
            rd_cnt_reg    <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    vndw_pkg::CFG_MODE:  mode_reg  <= cfg_data[1:0];
                    vndw_pkg::CFG_INV_X: inv_x_reg <= cfg_data;
                    vndw_pkg::CFG_INV_Y: inv_y_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                    pass_reg <= 3'd0;
                S_MYW:
                    oct_reg <= 2'd0;
                S_IDX:
                    rd_cnt_reg <= 3'd0;
                S_RD:
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                S_ACC:
                    oct_reg <= oct_reg + 2'd1;
                S_FBM:
                    pass_reg <= pass_reg + 3'd1;
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_reg <= x_coord;
                y_reg <= y_coord;
                if (mode_reg == vndw_pkg::MODE_PLAIN || mode_reg == vndw_pkg::MODE_FBM)
                begin
                    cx_reg <= x_coord;
                    cy_reg <= y_coord;
                end
                else
                begin
                    cx_reg <= vndw_pkg::warp_sum(x_coord, 17'sd0, vndw_pkg::OFF_X0);
                    cy_reg <= vndw_pkg::warp_sum(y_coord, 17'sd0, vndw_pkg::OFF_Y0);
                end
            end
            S_MX:
                mul_reg <= mul_p[63:0];
            S_MY:
            begin
                prx_reg <= mul_reg;
                mul_reg <= mul_p[63:0];
            end
            S_MYW:
            begin
                pry_reg <= mul_reg;
                acc_reg <= '0;
            end
            S_IDX:
            begin
                ix1_reg <= sx.idx[GXB-1:0];
                ix2_reg <= (sx.frac > 17'sd0) ? GXB'(sx.idx + 32'sd1) : GXB'(sx.idx - 32'sd1);
                iy1_reg <= sy.idx[GYB-1:0];
                iy2_reg <= (sy.frac > 17'sd0) ? GYB'(sy.idx + 32'sd1) : GYB'(sy.idx - 32'sd1);
                wx_reg  <= sx.frac[16] ? 17'(-sx.frac) : 17'(sx.frac);
                wy_reg  <= sy.frac[16] ? 17'(-sy.frac) : 17'(sy.frac);
            end
            S_RD:
                if (rd_cnt_reg != 3'd0)
                    t_reg[rd_cnt_reg[1:0] - 2'd1] <= mem_q;
            S_LA:
                mul_reg <= mul_p[63:0];
            S_LB:
            begin
                a_reg   <= (34'(t_reg[0]) <<< 16) + $signed(mul_reg[33:0]);
                mul_reg <= mul_p[63:0];
            end
            S_LV:
                b_reg <= (34'(t_reg[2]) <<< 16) + $signed(mul_reg[33:0]);
            S_LW:
                mul_reg <= mul_p[63:0];
            S_ACC:
                acc_reg <= acc_reg + (56'(vsum) <<< (2'd3 - oct_reg));
            S_FBM:
            begin
                res_reg <= fbm_r;
                case (pass_reg)
                    3'd0:
                    begin
                        x2_reg <= fbm_r;
                        cx_reg <= x_reg;
                        cy_reg <= y_reg;
                    end
                    3'd1:
                    begin
                        y2_reg <= fbm_r;
                        cx_reg <= vndw_pkg::warp_sum(x_reg, x2_reg, vndw_pkg::OFF_X2);
                        cy_reg <= vndw_pkg::warp_sum(y_reg, fbm_r, vndw_pkg::OFF_Y2);
                    end
                    3'd2:
                    begin
                        x3_reg <= fbm_r;
                        cx_reg <= vndw_pkg::warp_sum(x_reg, x2_reg, vndw_pkg::OFF_X3);
                        cy_reg <= vndw_pkg::warp_sum(y_reg, y2_reg, vndw_pkg::OFF_Y3);
                    end
                    3'd3:
                    begin
                        cx_reg <= vndw_pkg::warp_sum(x_reg, x3_reg, 32'sd0);
                        cy_reg <= vndw_pkg::warp_sum(y_reg, fbm_r, 32'sd0);
                    end
                    default: ;
                endcase
            end
            S_DONE:
                if (out_free)
                    noise_value_reg <= res_reg;
            default: ;
        endcase
    end

endmodule

>>> sv/vndw_checker.sv
// Port-level checker for the value noise warp block, with its bind.
`include "value_noise_domain_warp_assert.svh"

module vndw_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               operation,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [16:0] noise_value
);

    `VNDW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(noise_value), "stalled result changed")
    `VNDW_ASSERT_NOW(a_out_range, out_valid, (noise_value <= 17'(vndw_pkg::OUT_LIM)) && (noise_value >= -17'(vndw_pkg::OUT_LIM)), "result outside saturation range")
    `VNDW_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && operation == vndw_pkg::OP_EVAL, in_stall, "evaluate transaction did not make the block busy")

endmodule

bind value_noise_domain_warp vndw_checker u_vndw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value)
);

>>> verif/tb_value_noise_domain_warp.sv
// Self-checking testbench for the value noise / fBm / domain warp evaluator.
`timescale 1ns / 1ps

module tb_value_noise_domain_warp;

    // Mode code the package does not name
    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, acts as warp
    localparam logic [31:0] SCALE_ONE = 32'd65536;
    localparam int TABLE_MAX = 20480;
    localparam int SETTLE_CYCLES = 400;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               operation;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic [13:0]        table_index;
    logic signed [15:0] table_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [16:0] noise_value;

    value_noise_domain_warp dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .table_index (table_index),
        .table_value (table_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block state and the noise predictor
    // ------------------------------------------------------------------
    logic [1:0]         shadow_mode;
    logic [31:0]        shadow_sx;
    logic [31:0]        shadow_sy;
    logic signed [15:0] shadow_table [vndw_pkg::CELLS];

    logic signed [16:0] noise_q [$];    // expected noise values, oldest first
    int                 errors;
    bit                 calm;           // no random idling on either side
    int                 hold_request;   // long receiver hold-off, in cycles

    // Round half away from zero to a cell index; fraction is what is left.
    function automatic void cell_split(input longint p, output longint idx,
                                       output longint frac);
        if (p >= 0)
            idx = (p + 32768) >>> 16;
        else
            idx = -((-p + 32768) >>> 16);
        frac = p - idx * 65536;
    endfunction

    function automatic longint cell_at(input longint cx, input longint cy);
        return longint'(shadow_table[(cy & (vndw_pkg::GRID_Y - 1)) * vndw_pkg::GRID_X
                                     + (cx & (vndw_pkg::GRID_X - 1))]);
    endfunction

    // Bilinear value noise at a Q.16 position, exact in Q.43.
    function automatic longint bilinear(input longint px, input longint py);
        longint ix, iy, dx, dy, nx, ny, wx, wy, a, b;
        cell_split(px, ix, dx);
        cell_split(py, iy, dy);
        nx = dx > 0 ? ix + 1 : ix - 1;
        ny = dy > 0 ? iy + 1 : iy - 1;
        wx = dx < 0 ? -dx : dx;
        wy = dy < 0 ? -dy : dy;
        a = (65536 - wx) * cell_at(ix, iy) + wx * cell_at(nx, iy);
        b = (65536 - wx) * cell_at(ix, ny) + wx * cell_at(nx, ny);
        return (65536 - wy) * a + wy * b;
    endfunction

    // Octave k: coordinates scaled, then divided by 2^k with floor.
    function automatic longint octave_at(input longint x, input longint y, input int k);
        longint px, py;
        px = (x * longint'({32'd0, shadow_sx})) >>> (16 + k);
        py = (y * longint'({32'd0, shadow_sy})) >>> (16 + k);
        return bilinear(px, py);
    endfunction

    function automatic longint clamp_out(input longint v);
        return v < -vndw_pkg::OUT_LIM ? -vndw_pkg::OUT_LIM :
               (v > vndw_pkg::OUT_LIM ? vndw_pkg::OUT_LIM : v);
    endfunction

    function automatic longint clamp_coord(input longint v);
        return v < -64'sd2147483648 ? -64'sd2147483648 :
               (v > 64'sd2147483647 ? 64'sd2147483647 : v);
    endfunction

    function automatic longint fractal_sum(input longint x, input longint y);
        longint s;
        s = 8 * octave_at(x, y, 0) + 4 * octave_at(x, y, 1) +
            2 * octave_at(x, y, 2) + octave_at(x, y, 3);
        return clamp_out((s + (64'sd1 <<< 34)) >>> 35);
    endfunction

    function automatic longint warped_noise(input longint x, input longint y);
        longint qx, qy, rx, ry;
        qx = fractal_sum(clamp_coord(x + vndw_pkg::OFF_X0),
                         clamp_coord(y + vndw_pkg::OFF_Y0));
        qy = fractal_sum(x, y);
        rx = fractal_sum(clamp_coord(x + 128 * qx + vndw_pkg::OFF_X2),
                         clamp_coord(y + 128 * qy + vndw_pkg::OFF_Y2));
        ry = fractal_sum(clamp_coord(x + 128 * qx + vndw_pkg::OFF_X3),
                         clamp_coord(y + 128 * qy + vndw_pkg::OFF_Y3));
        return fractal_sum(clamp_coord(x + 128 * rx), clamp_coord(y + 128 * ry));
    endfunction

    function automatic logic signed [16:0] predict_noise(input logic signed [31:0] x,
                                                         input logic signed [31:0] y);
        longint r;
        if (shadow_mode == vndw_pkg::MODE_PLAIN)
            r = clamp_out((octave_at(x, y, 0) + (64'sd1 <<< 31)) >>> 32);
        else if (shadow_mode == vndw_pkg::MODE_FBM)
            r = fractal_sum(x, y);
        else
            r = warped_noise(x, y);
        return r[16:0];
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("tb_value_noise_domain_warp: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= calm ? 1'b0 : ($urandom_range(99) < 7);
        end
    end

    // Result checker: every accepted transaction against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (noise_q.size() == 0)
            begin
                $display("%0t: unexpected result noise_value=%0d", $time, noise_value);
                errors++;
            end
            else
            begin
                logic signed [16:0] want;
                want = noise_q.pop_front();
                if (noise_value !== want)
                begin
                    $display("%0t: noise_value expected %0d actual %0d",
                             $time, want, noise_value);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Drive one transaction; track the shadow state when it is accepted.
    // A typed expectation, when given, replaces the predicted one.
    task automatic send(input logic op, input logic signed [31:0] x,
                        input logic signed [31:0] y, input logic [13:0] idx,
                        input logic signed [15:0] val, input bit typed = 0,
                        input logic signed [16:0] typed_value = '0);
        @(negedge clk);
        if (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        x_coord     <= x;
        y_coord     <= y;
        table_index <= idx;
        table_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        if (op == vndw_pkg::OP_LOAD)
            shadow_table[idx] = val;   // every 14-bit index is inside the grid
        else
            noise_q.push_back(typed ? typed_value : predict_noise(x, y));
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait for every expected result, then for a possible trailing pass.
    task automatic settle();
        go_idle();
        while (noise_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == vndw_pkg::CFG_MODE)
            shadow_mode = data[1:0];
        else if (idx == vndw_pkg::CFG_INV_X)
            shadow_sx = data;
        else
            shadow_sy = data;
    endtask

    task automatic set_config(input logic [1:0] m, input logic [31:0] sx,
                              input logic [31:0] sy);
        settle();
        write_reg(vndw_pkg::CFG_MODE, {30'd0, m});
        write_reg(vndw_pkg::CFG_INV_X, sx);
        write_reg(vndw_pkg::CFG_INV_Y, sy);
    endtask

    // Fill every table entry so no evaluation reads an unwritten cell.
    task automatic fill_table(input bit constant);
        for (int i = 0; i < vndw_pkg::CELLS; i++)
            send(vndw_pkg::OP_LOAD, '0, '0, i[13:0],
                 constant ? 16'(TABLE_MAX) : 16'($urandom_range(2 * TABLE_MAX) - TABLE_MAX));
    endtask

    function automatic logic signed [31:0] rand_coord();
        int r;
        r = $urandom_range(9);
        if (r < 4)   // a few hundred cells around the origin
            return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
        else if (r < 6) // exact halves: rounding ties
            return ($signed($urandom_range(400)) - 200) * 65536 + 32768;
        else if (r == 6) // exact cells: zero fraction
            return ($signed($urandom_range(400)) - 200) * 65536;
        else
            return $urandom;
    endfunction

    // Directed stimulus: a config row switches settings, other rows are transactions.
    typedef struct {
        bit                 is_cfg;
        logic [1:0]         m;
        logic [31:0]        sx, sy;
        logic               op;
        logic signed [31:0] x, y;
        logic [13:0]        idx;
        logic signed [15:0] val;
        bit                 typed;
        logic signed [16:0] want;
    } stim_row_t;

    function automatic stim_row_t cfg_row(input logic [1:0] m, input logic [31:0] sx,
                                          input logic [31:0] sy);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1; r.m = m; r.sx = sx; r.sy = sy;
        return r;
    endfunction

    function automatic stim_row_t eval_row(input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input bit typed, input int want);
        stim_row_t r;
        r = '{default: '0};
        r.op = vndw_pkg::OP_EVAL; r.x = x; r.y = y; r.typed = typed; r.want = 17'(want);
        return r;
    endfunction

    function automatic stim_row_t load_row(input logic [13:0] idx,
                                           input logic signed [15:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.op = vndw_pkg::OP_LOAD; r.idx = idx; r.val = val;
        return r;
    endfunction

    localparam logic signed [31:0] XMAX = 32'sh7fffffff;
    localparam logic signed [31:0] XMIN = 32'sh80000000;

    initial
    begin
        stim_row_t directed [$];
        logic [1:0] m;

        errors = 0;
        calm = 0;
        hold_request = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = vndw_pkg::CFG_MODE;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = vndw_pkg::OP_LOAD;
        x_coord = '0;
        y_coord = '0;
        table_index = '0;
        table_value = '0;
        shadow_mode = vndw_pkg::MODE_WARP;
        shadow_sx = SCALE_ONE;
        shadow_sy = SCALE_ONE;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With a flat table every mode gives the table value, times 15/8 for fBm
        // and warp: the top value lands exactly on the output limit.
        fill_table(1);
        directed = '{
            eval_row(0, 0, 1, vndw_pkg::OUT_LIM),                 // reset mode is warp
            eval_row(XMAX, XMAX, 1, vndw_pkg::OUT_LIM),
            eval_row(XMIN, XMIN, 1, vndw_pkg::OUT_LIM),
            cfg_row(vndw_pkg::MODE_PLAIN, SCALE_ONE, SCALE_ONE),
            eval_row(XMIN, XMAX, 1, TABLE_MAX),
            eval_row(32768, -32768, 1, TABLE_MAX),                // ties both ways
            cfg_row(vndw_pkg::MODE_FBM, 32'hffffffff, 32'hffffffff),
            eval_row(XMAX, XMIN, 1, vndw_pkg::OUT_LIM),
            cfg_row(MODE_SPARE, 32'd1, 32'd1),
            eval_row(32'sh12345, -32'sh54321, 1, vndw_pkg::OUT_LIM),
            load_row(14'd0, -16'sd20480),
            load_row(14'h3fff, 16'sd20480),
            load_row(14'd129, 16'sd0),
            cfg_row(vndw_pkg::MODE_PLAIN, SCALE_ONE, SCALE_ONE),
            eval_row(0, 0, 1, -TABLE_MAX),                        // zero fraction, lower cell
            eval_row(65536 + 20000, 65536 - 9000, 0, 0),
            eval_row(-32768, -32768, 0, 0),
            eval_row(-100, 100, 0, 0),
            cfg_row(vndw_pkg::MODE_FBM, SCALE_ONE, SCALE_ONE),
            eval_row(40000, -70000, 0, 0),
            cfg_row(vndw_pkg::MODE_PLAIN, 32'd0, 32'd0),          // zero scale: origin cell
            eval_row(XMAX, XMIN, 1, -TABLE_MAX),
            cfg_row(vndw_pkg::MODE_WARP, SCALE_ONE, 32'd0),
            eval_row(300000, 5, 0, 0)
        };
        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
                set_config(directed[i].m, directed[i].sx, directed[i].sy);
            else
                send(directed[i].op, directed[i].x, directed[i].y, directed[i].idx,
                     directed[i].val, directed[i].typed, directed[i].want);
        end

        // Random table, then random phases over several settings.
        settle();
        fill_table(0);
        for (int phase = 0; phase < 6; phase++)
        begin
            m = phase < 4 ? phase[1:0] : 2'($urandom_range(3));
            case (phase)
                0: set_config(vndw_pkg::MODE_PLAIN, SCALE_ONE, SCALE_ONE);
                1: set_config(vndw_pkg::MODE_FBM, 32'hffffffff, 32'd1);
                2: set_config(vndw_pkg::MODE_WARP, $urandom_range(32'h0004_0000), $urandom);
                default: set_config(m, $urandom_range(32'h0003_0000),
                                    $urandom_range(32'h0003_0000));
            endcase
            calm = (phase == 4);
            if (phase == 2)
                hold_request = 2000;    // block fills and stalls its input
            for (int n = 0; n < 125; n++)
            begin
                if ($urandom_range(9) == 0)
                    send(vndw_pkg::OP_LOAD, $urandom, $urandom, 14'($urandom),
                         16'($urandom_range(2 * TABLE_MAX) - TABLE_MAX));
                else
                    send(vndw_pkg::OP_EVAL, rand_coord(), rand_coord(), 14'($urandom),
                         16'($urandom));
            end
        end
        calm = 0;
        settle();

        if (errors == 0)
            $display("tb_value_noise_domain_warp: PASS");
        else
            $display("tb_value_noise_domain_warp: FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/vndw_pkg.sv
sv/value_noise_domain_warp.sv
sv/vndw_checker.sv
verif/tb_value_noise_domain_warp.sv
